@@ src/psk_pkg.sv @@
// ----------------------------------------------------------------------------
// psk_pkg
// shared types, constants and key maps for the ps/2 scancode keyboard fifo
// ----------------------------------------------------------------------------
package psk_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  localparam int CHAR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int FILL_W  = 7;

  localparam logic [COUNT_W-1:0] READ_MAX = COUNT_W'(64);

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  localparam logic [6:0]        KEY_LSHIFT = 7'h2A;
  localparam logic [6:0]        KEY_RSHIFT = 7'h36;
  localparam logic [6:0]        KEY_CTRL   = 7'h1D;
  localparam logic [6:0]        KEY_CAPS   = 7'h3A;
  localparam logic [BYTE_W-1:0] KEY_PREFIX = 8'hE0;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 7'd32;

  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_C = 7'h63;
  localparam logic [CHAR_W-1:0] CH_UPPER_C = 7'h43;

  typedef struct packed {
    logic              push;
    logic              intr;
    logic [CHAR_W-1:0] ch;
  } key_evt_t;

  function automatic logic [CHAR_W-1:0] key_map(input logic [6:0] code,
                                                input logic shifted);
    logic [CHAR_W-1:0] p;
    logic [CHAR_W-1:0] s;
    unique case (code)
      7'h02: p = 7'h31;
      7'h03: p = 7'h32;
      7'h04: p = 7'h33;
      7'h05: p = 7'h34;
      7'h06: p = 7'h35;
      7'h07: p = 7'h36;
      7'h08: p = 7'h37;
      7'h09: p = 7'h38;
      7'h0A: p = 7'h39;
      7'h0B: p = 7'h30;
      7'h0C: p = 7'h2D;
      7'h0D: p = 7'h3D;
      7'h0E: p = 7'h08;
      7'h0F: p = 7'h09;
      7'h10: p = 7'h71;
      7'h11: p = 7'h77;
      7'h12: p = 7'h65;
      7'h13: p = 7'h72;
      7'h14: p = 7'h74;
      7'h15: p = 7'h79;
      7'h16: p = 7'h75;
      7'h17: p = 7'h69;
      7'h18: p = 7'h6F;
      7'h19: p = 7'h70;
      7'h1A: p = 7'h5B;
      7'h1B: p = 7'h5D;
      7'h1C: p = 7'h0A;
      7'h1E: p = 7'h61;
      7'h1F: p = 7'h73;
      7'h20: p = 7'h64;
      7'h21: p = 7'h66;
      7'h22: p = 7'h67;
      7'h23: p = 7'h68;
      7'h24: p = 7'h6A;
      7'h25: p = 7'h6B;
      7'h26: p = 7'h6C;
      7'h27: p = 7'h3B;
      7'h28: p = 7'h27;
      7'h29: p = 7'h60;
      7'h2B: p = 7'h5C;
      7'h2C: p = 7'h7A;
      7'h2D: p = 7'h78;
      7'h2E: p = 7'h63;
      7'h2F: p = 7'h76;
      7'h30: p = 7'h62;
      7'h31: p = 7'h6E;
      7'h32: p = 7'h6D;
      7'h33: p = 7'h2C;
      7'h34: p = 7'h2E;
      7'h35: p = 7'h2F;
      7'h37: p = 7'h2A;
      7'h39: p = 7'h20;
      7'h47: p = 7'h37;
      7'h48: p = 7'h38;
      7'h49: p = 7'h39;
      7'h4A: p = 7'h2D;
      7'h4B: p = 7'h34;
      7'h4C: p = 7'h35;
      7'h4D: p = 7'h36;
      7'h4E: p = 7'h2B;
      7'h4F: p = 7'h31;
      7'h50: p = 7'h32;
      7'h51: p = 7'h33;
      7'h52: p = 7'h30;
      7'h53: p = 7'h2E;
      default: p = 7'h00;
    endcase
    if (p >= CH_LOWER_A && p <= CH_LOWER_Z) begin
      s = p - CASE_DELTA;
    end else begin
      unique case (code)
        7'h02: s = 7'h21;
        7'h03: s = 7'h40;
        7'h04: s = 7'h23;
        7'h05: s = 7'h24;
        7'h06: s = 7'h25;
        7'h07: s = 7'h5E;
        7'h08: s = 7'h26;
        7'h09: s = 7'h2A;
        7'h0A: s = 7'h28;
        7'h0B: s = 7'h29;
        7'h0C: s = 7'h5F;
        7'h0D: s = 7'h2B;
        7'h1A: s = 7'h7B;
        7'h1B: s = 7'h7D;
        7'h27: s = 7'h3A;
        7'h28: s = 7'h22;
        7'h29: s = 7'h7E;
        7'h2B: s = 7'h7C;
        7'h33: s = 7'h3C;
        7'h34: s = 7'h3E;
        7'h35: s = 7'h3F;
        default: s = p;
      endcase
    end
    return shifted ? s : p;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

@@ src/psk_ram.sv @@
// ----------------------------------------------------------------------------
// psk_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module psk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/psk_decode.sv @@
// ----------------------------------------------------------------------------
// psk_decode
// set-1 scancode decoder with shift, ctrl, caps lock and prefix tracking
// ----------------------------------------------------------------------------
module psk_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         strobe,
  input  logic                         clear,
  input  logic [psk_pkg::BYTE_W-1:0]   scan_byte,
  output psk_pkg::key_evt_t            evt
);

  import psk_pkg::*;

  logic shift_held;
  logic ctrl_held;
  logic caps_active;
  logic prefix_seen;

  logic [6:0]        code;
  logic              rel;
  logic              is_prefix;
  logic              is_shift;
  logic              is_ctrl;
  logic              is_caps;
  logic              is_char;
  logic [CHAR_W-1:0] mapped;
  logic [CHAR_W-1:0] ch;

  assign code      = scan_byte[6:0];
  assign rel       = scan_byte[7];
  assign is_prefix = (scan_byte == KEY_PREFIX);
  assign is_shift  = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
  assign is_ctrl   = (code == KEY_CTRL);
  assign is_caps   = (code == KEY_CAPS);
  assign mapped    = key_map(code, shift_held);

  always_comb begin
    ch = mapped;
    if (caps_active && mapped >= CH_LOWER_A && mapped <= CH_LOWER_Z) begin
      ch = mapped - CASE_DELTA;
    end else if (caps_active && mapped >= CH_UPPER_A && mapped <= CH_UPPER_Z) begin
      ch = mapped + CASE_DELTA;
    end
  end

  assign is_char = !is_prefix && !prefix_seen && !is_shift && !is_ctrl && !is_caps &&
                   !rel && (mapped != '0);

  assign evt.push = is_char && !ctrl_held;
  assign evt.intr = is_char && ctrl_held && (ch == CH_LOWER_C || ch == CH_UPPER_C);
  assign evt.ch   = ch;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      caps_active <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (strobe) begin
      priority if (is_prefix) begin
        prefix_seen <= 1'b1;
      end else if (prefix_seen) begin
        prefix_seen <= 1'b0;
      end else if (is_shift) begin
        shift_held <= !rel;
      end else if (is_ctrl) begin
        ctrl_held <= !rel;
      end else if (is_caps && !rel) begin
        caps_active <= !caps_active;
      end
    end
  end

endmodule

@@ src/ps2_scancode_keyboard_fifo_core.sv @@
// ----------------------------------------------------------------------------
// ps2_scancode_keyboard_fifo_core
// ps/2 set-1 keyboard front end with a character fifo
// ----------------------------------------------------------------------------
// Scancode, clear and unused-opcode words give one result word, loaded into the
// output register at the accept edge. A read gives one result word per character;
// each character is addressed in ST_ADDR, read through the registered ram port and
// loaded into the output register in ST_DATA, which waits on a stalled output; an
// empty or zero-length read gives a single result at once. A new input word is taken
// only when the block is idle and the output register is free or being taken.
// The character ram needs no clearing pass: only occupied entries are read.
module ps2_scancode_keyboard_fifo_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [psk_pkg::BYTE_W-1:0]    scan_byte,
  input  logic [psk_pkg::COUNT_W-1:0]   read_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          char_valid,
  output logic [psk_pkg::CHAR_W-1:0]    char_code,
  output logic                          interrupt_event,
  output logic                          dropped_full,
  output logic [psk_pkg::FILL_W-1:0]    fill_level,
  output logic                          last
);

  import psk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_DATA = 3'b100
  } state_t;

  state_t             state;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [OCC_W-1:0]   occ;
  logic [COUNT_W-1:0] remain;

  logic               out_free;
  logic               acc;
  logic               scan_acc;
  logic               clear_acc;
  logic               full;
  logic               push_ok;
  logic [COUNT_W-1:0] want;
  logic               rd_last;
  logic [CHAR_W-1:0]  rdata;
  key_evt_t           evt;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign scan_acc  = acc && (opcode == OP_SCAN);
  assign clear_acc = acc && (opcode == OP_CLEAR);
  assign full      = (occ >= OCC_W'(FIFO_DEPTH));
  assign push_ok   = scan_acc && evt.push && !full;
  assign want      = (read_count > READ_MAX) ? READ_MAX : read_count;
  assign rd_last   = (remain == COUNT_W'(1)) || (occ == OCC_W'(1));

  psk_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .strobe    (scan_acc),
    .clear     (clear_acc),
    .scan_byte (scan_byte),
    .evt       (evt)
  );

  psk_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_ptr),
    .wdata (evt.ch),
    .re    (state == ST_ADDR),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      occ       <= '0;
      remain    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            char_valid      <= 1'b0;
            char_code       <= '0;
            interrupt_event <= 1'b0;
            dropped_full    <= 1'b0;
            last            <= 1'b1;
            fill_level      <= FILL_W'(occ);
            out_valid       <= 1'b1;
            unique case (opcode)
              OP_SCAN: begin
                interrupt_event <= evt.intr;
                dropped_full    <= evt.push && full;
                if (push_ok) begin
                  wr_ptr     <= ptr_inc(wr_ptr);
                  occ        <= occ + OCC_W'(1);
                  fill_level <= FILL_W'(occ + OCC_W'(1));
                end
              end
              OP_READ: begin
                if (want != '0 && occ != '0) begin
                  out_valid <= 1'b0;
                  remain    <= want;
                  state     <= ST_ADDR;
                end
              end
              OP_CLEAR: begin
                rd_ptr     <= '0;
                wr_ptr     <= '0;
                occ        <= '0;
                fill_level <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADDR: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            char_valid      <= 1'b1;
            char_code       <= rdata;
            interrupt_event <= 1'b0;
            dropped_full    <= 1'b0;
            last            <= rd_last;
            fill_level      <= FILL_W'(occ - OCC_W'(1));
            rd_ptr          <= ptr_inc(rd_ptr);
            occ             <= occ - OCC_W'(1);
            remain          <= remain - COUNT_W'(1);
            state           <= rd_last ? ST_IDLE : ST_ADDR;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/psk_checker.sv @@
// ----------------------------------------------------------------------------
// psk_checker
// port-level checks on the result stream of the keyboard fifo core
// ----------------------------------------------------------------------------
module psk_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] opcode,
  input logic [7:0] scan_byte,
  input logic [6:0] read_count,
  input logic       out_valid,
  input logic       out_ready,
  input logic       char_valid,
  input logic [6:0] char_code,
  input logic       interrupt_event,
  input logic       dropped_full,
  input logic [6:0] fill_level,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last) &&
                                $stable(fill_level) && $stable(char_valid))
    else $error("result word changed while stalled");

  a_empty_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> char_code == 7'd0)
    else $error("char_code nonzero on a result with no character");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= 7'd64)
    else $error("fill_level beyond fifo depth");

  a_read_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> !interrupt_event && !dropped_full)
    else $error("event flags set on a read result");

endmodule

bind ps2_scancode_keyboard_fifo_core psk_checker u_psk_checker (.*);
